>>> rtl/eipc_pkg.sv
`timescale 1ns / 1ps

package eipc_pkg;

    typedef enum logic [1:0] {
        NET_OTHER = 2'd0,
        NET_IPV4  = 2'd1,
        NET_ARP   = 2'd2,
        NET_IPV6  = 2'd3
    } net_kind_t;

    typedef enum logic [2:0] {
        TRANS_OTHER = 3'd0,
        TRANS_TCP   = 3'd1,
        TRANS_UDP   = 3'd2,
        TRANS_ICMP  = 3'd3,
        TRANS_IGMP  = 3'd4,
        TRANS_6IN4  = 3'd5
    } trans_kind_t;

    typedef enum logic [2:0] {
        APP_NONE     = 3'd0,
        APP_HTTP     = 3'd1,
        APP_DNS      = 3'd2,
        APP_HTTPS    = 3'd3,
        APP_SSDP     = 3'd4,
        APP_NB_NAME  = 3'd5,
        APP_NB_DGRAM = 3'd6,
        APP_NB_SESS  = 3'd7
    } app_kind_t;

    localparam int POS_W = 7;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [POS_W-1:0] POS_ETYPE_HI = 7'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 7'd13;
    localparam logic [POS_W-1:0] POS_IHL      = 7'd14;
    localparam logic [POS_W-1:0] POS_V6_NEXT  = 7'd20;
    localparam logic [POS_W-1:0] POS_V4_PROTO = 7'd23;
    localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
    localparam logic [POS_W-1:0] V6_L4_START  = 7'd54;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_6IN4 = 8'd41;

    localparam logic [15:0] PORT_HTTP     = 16'd80;
    localparam logic [15:0] PORT_DNS      = 16'd53;
    localparam logic [15:0] PORT_HTTPS    = 16'd443;
    localparam logic [15:0] PORT_SSDP     = 16'd1900;
    localparam logic [15:0] PORT_NB_NAME  = 16'd137;
    localparam logic [15:0] PORT_NB_DGRAM = 16'd138;
    localparam logic [15:0] PORT_NB_SESS  = 16'd139;

    localparam logic [2:0] PORT_BYTES = 3'd4;

    // address width, register index and reset value of the single control register
    localparam int          PADDR_W      = 3;
    localparam logic        REG_LINK_IDX = 1'b0;
    localparam logic [31:0] LINK_RESET   = 32'd1;

    // frame summary handed from parser to classifier
    typedef struct packed {
        logic        link;
        logic        short_eth;
        logic        short_l3;
        net_kind_t   net;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        ports_ok;
    } summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        net_kind_t   net_class;
        trans_kind_t trans_class;
        app_kind_t   app_class;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        truncated;
    } result_t;

    function automatic trans_kind_t trans_of(input logic [7:0] proto, input logic ipv4);
        trans_kind_t t;
        case (proto)
            PROTO_TCP:  t = TRANS_TCP;
            PROTO_UDP:  t = TRANS_UDP;
            PROTO_ICMP: t = TRANS_ICMP;
            PROTO_IGMP: t = TRANS_IGMP;
            PROTO_6IN4: t = ipv4 ? TRANS_6IN4 : TRANS_OTHER;
            default:    t = TRANS_OTHER;
        endcase
        return t;
    endfunction

    function automatic app_kind_t app_of(input logic [15:0] port, input logic udp);
        app_kind_t a;
        case (port)
            PORT_HTTP:     a = APP_HTTP;
            PORT_DNS:      a = APP_DNS;
            PORT_HTTPS:    a = APP_HTTPS;
            PORT_SSDP:     a = udp ? APP_SSDP : APP_NONE;
            PORT_NB_NAME:  a = APP_NB_NAME;
            PORT_NB_DGRAM: a = APP_NB_DGRAM;
            PORT_NB_SESS:  a = APP_NB_SESS;
            default:       a = APP_NONE;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/eipc_if.sv
`timescale 1ns / 1ps

interface eipc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface eipc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  net_class;
    logic [2:0]  trans_class;
    logic [2:0]  app_class;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        truncated;

    modport source (output valid, output net_class, output trans_class, output app_class,
                    output ip_protocol, output source_port, output dest_port,
                    output truncated, input ready);
    modport sink   (input valid, input net_class, input trans_class, input app_class,
                    input ip_protocol, input source_port, input dest_port,
                    input truncated, output ready);
endinterface

>>> rtl/eipc_front.sv
`timescale 1ns / 1ps

module eipc_front (
    input  logic              clk,
    input  logic              rst_n,
    eipc_in_if.sink           in_ch,
    input  logic              link_is_ethernet,
    input  eipc_pkg::q_status_t q_status,
    output logic              push,
    output eipc_pkg::summary_t push_entry
);
    import eipc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       etype_hi_reg, etype_hi_next;
    net_kind_t        net_reg, net_next;
    logic [7:0]       proto_reg, proto_next;
    logic [POS_W-1:0] tstart_reg, tstart_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic [2:0]       seen_reg, seen_next;

    logic             accept;
    logic [7:0]       b;
    logic [POS_W-1:0] offs;
    logic             capture;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && in_ch.last_byte;
    assign b           = in_ch.frame_byte;
    assign offs        = pos_reg - tstart_next;

    always_comb
    begin
        etype_hi_next = etype_hi_reg;
        net_next      = net_reg;
        tstart_next   = tstart_reg;
        proto_next    = proto_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        seen_next     = seen_reg;

        if (pos_reg == POS_ETYPE_HI)
        begin
            etype_hi_next = b;
        end
        else if (pos_reg == POS_ETYPE_LO)
        begin
            case ({etype_hi_reg, b})
                ETYPE_IPV4: net_next = NET_IPV4;
                ETYPE_ARP:  net_next = NET_ARP;
                ETYPE_IPV6:
                begin
                    net_next    = NET_IPV6;
                    tstart_next = V6_L4_START;
                end
                default:    net_next = NET_OTHER;
            endcase
        end

        // IPv4 header length in 32-bit words sets the transport offset
        if (pos_reg == POS_IHL && net_next == NET_IPV4)
            tstart_next = POS_IHL + {1'b0, b[3:0], 2'b00};

        if ((pos_reg == POS_V4_PROTO && net_next == NET_IPV4) ||
            (pos_reg == POS_V6_NEXT && net_next == NET_IPV6))
            proto_next = b;

        capture = (pos_reg >= POS_IHL) && (net_next == NET_IPV4 || net_next == NET_IPV6) &&
                  (pos_reg >= tstart_next) && (offs < POS_W'(PORT_BYTES));
        if (capture)
        begin
            if (!offs[1])
                src_next = {src_reg[7:0], b};
            else
                dst_next = {dst_reg[7:0], b};
            if (seen_reg < PORT_BYTES)
                seen_next = seen_reg + 3'd1;
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;

        push_entry.link      = link_is_ethernet;
        push_entry.short_eth = pos_reg < POS_ETYPE_LO;
        push_entry.short_l3  = (net_next == NET_IPV4) ? (pos_reg < POS_V4_PROTO)
                                                      : (pos_reg < POS_V6_NEXT);
        push_entry.net       = net_next;
        push_entry.proto     = proto_next;
        push_entry.sport     = src_next;
        push_entry.dport     = dst_next;
        push_entry.ports_ok  = seen_next >= PORT_BYTES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            etype_hi_reg <= '0;
            net_reg      <= NET_OTHER;
            proto_reg    <= '0;
            tstart_reg   <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            seen_reg     <= '0;
        end
        else if (accept)
        begin
            if (in_ch.last_byte)
            begin
                pos_reg      <= '0;
                etype_hi_reg <= '0;
                net_reg      <= NET_OTHER;
                proto_reg    <= '0;
                tstart_reg   <= '0;
                src_reg      <= '0;
                dst_reg      <= '0;
                seen_reg     <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                etype_hi_reg <= etype_hi_next;
                net_reg      <= net_next;
                proto_reg    <= proto_next;
                tstart_reg   <= tstart_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
                seen_reg     <= seen_next;
            end
        end
    end

endmodule

>>> rtl/eipc_queue.sv
`timescale 1ns / 1ps

module eipc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  eipc_pkg::summary_t  push_entry,
    input  logic                pop,
    output eipc_pkg::q_status_t q_status,
    output eipc_pkg::summary_t  head
);
    import eipc_pkg::*;

    summary_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_status.full  = count_reg == 2'd2;
    assign q_status.empty = count_reg == 2'd0;
    assign head           = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/eipc_back.sv
`timescale 1ns / 1ps

module eipc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  eipc_pkg::q_status_t q_status,
    input  eipc_pkg::summary_t  head,
    output logic                pop,
    eipc_out_if.source          out_ch
);
    import eipc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    result_t   res_reg, res_next;
    logic      ip_net, l3_ok, tcp_udp, l4_ok, udp;
    app_kind_t app_src, app_dst;

    assign pop = !q_status.empty && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        res_next = '0;

        ip_net  = head.net == NET_IPV4 || head.net == NET_IPV6;
        l3_ok   = head.link && !head.short_eth && ip_net && !head.short_l3;
        res_next.trans_class = l3_ok ? trans_of(head.proto, head.net == NET_IPV4)
                                     : TRANS_OTHER;
        tcp_udp = res_next.trans_class == TRANS_TCP || res_next.trans_class == TRANS_UDP;
        l4_ok   = tcp_udp && head.ports_ok;
        udp     = res_next.trans_class == TRANS_UDP;
        app_src = app_of(head.sport, udp);
        app_dst = app_of(head.dport, udp);

        res_next.net_class   = (head.link && !head.short_eth) ? head.net : NET_OTHER;
        res_next.ip_protocol = l3_ok ? head.proto : 8'd0;
        if (l4_ok)
        begin
            res_next.source_port = head.sport;
            res_next.dest_port   = head.dport;
            // UDP favors the destination port, TCP the source port
            if (udp)
                res_next.app_class = (app_dst != APP_NONE) ? app_dst : app_src;
            else
                res_next.app_class = (app_src != APP_NONE) ? app_src : app_dst;
        end
        res_next.truncated = head.link &&
                             (head.short_eth || (ip_net && head.short_l3) ||
                              (l3_ok && tcp_udp && !head.ports_ok));

        out_valid_next = pop ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.net_class   = res_reg.net_class;
    assign out_ch.trans_class = res_reg.trans_class;
    assign out_ch.app_class   = res_reg.app_class;
    assign out_ch.ip_protocol = res_reg.ip_protocol;
    assign out_ch.source_port = res_reg.source_port;
    assign out_ch.dest_port   = res_reg.dest_port;
    assign out_ch.truncated   = res_reg.truncated;

endmodule

>>> rtl/ethernet_ip_port_classifier_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields                                        Transfer
// -------   ---  --------------------------------------------  ------------------
// in_ch     in   frame_byte[7:0], last_byte                    valid && ready
// out_ch    out  net_class, trans_class, app_class,            valid && ready
//                ip_protocol, source_port, dest_port, truncated
// apb       in   link_is_ethernet at paddr 0                   psel&&penable&&pwrite
//
// One byte is taken every cycle while the queue is not full; the queue entry
// is written at the transfer of a frame's last byte, and the result register
// loads it from the queue head once free; out_ch.valid follows that register.
// The per-byte parser update is a combinational compare and a register load.
// Reset is asynchronous and active low; it clears the parser, the queue
// and the output valid, and sets link_is_ethernet to 1.
// A two-entry queue separates parser and classifier: in_ch.ready drops only
// while the queue is full, which takes two finished frames waiting behind a
// stalled result in the output register.

module ethernet_ip_port_classifier_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [eipc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    eipc_in_if.sink                      in_ch,
    eipc_out_if.source                   out_ch
);
    import eipc_pkg::*;

    logic      link_reg, link_next;
    logic      cfg_wr;
    q_status_t q_status;
    summary_t  push_entry;
    summary_t  head;
    logic      push;
    logic      pop;

    // Register file: one control bit, word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LINK_IDX);

    always_comb
    begin
        link_next = cfg_wr ? pwdata[0] : link_reg;
        prdata    = (paddr[2] == REG_LINK_IDX) ? {31'd0, link_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_reg <= LINK_RESET[0];
        else
            link_reg <= link_next;
    end

    // Front: track byte position and capture header fields; hand one
    // summary per frame to the queue on the last byte
    eipc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .link_is_ethernet (link_reg),
        .q_status         (q_status),
        .push             (push),
        .push_entry       (push_entry)
    );

    // Hold finished frame summaries while the output stalls
    eipc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_status   (q_status),
        .head       (head)
    );

    // Back: map protocol and ports to classes, drive the output register
    eipc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

>>> rtl/eipc_checker.sv
`timescale 1ns / 1ps

module eipc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  net_class,
    input logic [2:0]  trans_class,
    input logic [7:0]  ip_protocol,
    input logic [15:0] source_port,
    input logic [15:0] dest_port,
    input logic [2:0]  app_class
);
    import eipc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(net_class) && $stable(trans_class) &&
            $stable(app_class) && $stable(ip_protocol) && $stable(source_port) &&
            $stable(dest_port))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while no result is pending");

    a_non_ip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && net_class != NET_IPV4 && net_class != NET_IPV6 |->
            trans_class == TRANS_OTHER && ip_protocol == 8'd0 &&
            source_port == 16'd0 && dest_port == 16'd0 && app_class == APP_NONE)
        else $error("transport fields set on a non-IP frame");

endmodule

bind ethernet_ip_port_classifier_core eipc_checker u_eipc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .net_class   (out_ch.net_class),
    .trans_class (out_ch.trans_class),
    .ip_protocol (out_ch.ip_protocol),
    .source_port (out_ch.source_port),
    .dest_port   (out_ch.dest_port),
    .app_class   (out_ch.app_class)
);
